>>> design/assert_macros.svh
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/sbbc_pkg.sv
// Package of types and constants for the scanline border ball check.
package sbbc_pkg;

    localparam int COORD_W = 11;
    localparam int DIST_W = 10;
    localparam int COUNT_W = 7;
    localparam int SQ_W = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int LIM_W = 2 * DIST_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = DIST_W;

    localparam int SCAN_LINES_DEFAULT = 10;

    localparam logic [DIST_W-1:0] NEAR_DIST_RESET = DIST_W'(20);
    localparam logic [COUNT_W-1:0] REJECT_RESET = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(127);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LINES = CFG_IDX_W'(1);

    // One classified pixel
    typedef struct packed {
        logic               inner_hit;
        logic               outer_hit;
        logic               field_hit;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               line_end;
    } pixel_t;

    // Summary of one finished scan line
    typedef struct packed {
        logic               valid;
        logic               candidate;
        logic               set_last;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } line_close_t;

endpackage

>>> design/sbbc_line_tracker.sv
// Per-line border tracking and line close stage of the scanline border ball check.
module sbbc_line_tracker
    import sbbc_pkg::*;
#(
    parameter int SCAN_LINES = SCAN_LINES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        pix_valid,
    input  pixel_t      pix,
    output line_close_t close,
    output logic [$clog2(SCAN_LINES+1)-1:0] line_index
);

    localparam int LINE_W = $clog2(SCAN_LINES + 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(SCAN_LINES - 1);

    logic               past_inner_reg, past_inner_next;
    logic               field_seen_reg, field_seen_next;
    logic               outer_seen_reg, outer_seen_next;
    logic [COORD_W-1:0] outer_x_reg, outer_x_next;
    logic [COORD_W-1:0] outer_y_reg, outer_y_next;
    logic [COORD_W-1:0] inner_x_reg, inner_x_next;
    logic [COORD_W-1:0] inner_y_reg, inner_y_next;
    logic [LINE_W-1:0]  line_index_reg, line_index_next;
    line_close_t        close_reg, close_next;
    logic               set_last;

    // Update the line state with the current pixel
    always_comb begin
        past_inner_next = past_inner_reg;
        field_seen_next = field_seen_reg;
        outer_seen_next = outer_seen_reg;
        outer_x_next    = outer_x_reg;
        outer_y_next    = outer_y_reg;
        inner_x_next    = inner_x_reg;
        inner_y_next    = inner_y_reg;
        if (!past_inner_reg) begin
            if (pix.inner_hit) begin
                past_inner_next = 1'b1;
            end
        end else begin
            if (pix.field_hit && !field_seen_reg) begin
                if (!outer_seen_reg) begin
                    field_seen_next = 1'b1;
                end
            end else if (pix.outer_hit && !outer_seen_reg) begin
                outer_seen_next = 1'b1;
                outer_x_next    = pix.pixel_x;
                outer_y_next    = pix.pixel_y;
            end
            if (pix.inner_hit) begin
                inner_x_next = pix.pixel_x;
                inner_y_next = pix.pixel_y;
            end
        end
    end

    // Count lines within the set
    assign set_last = (line_index_reg == LAST_LINE);
    always_comb begin
        line_index_next = line_index_reg;
        if (pix_valid && pix.line_end) begin
            line_index_next = set_last ? '0 : line_index_reg + LINE_W'(1);
        end
    end

    // Summarize the line at its last pixel
    always_comb begin
        close_next.valid     = pix_valid && pix.line_end;
        close_next.candidate = outer_seen_next && !field_seen_next;
        close_next.set_last  = set_last;
        close_next.dx = (inner_x_next > outer_x_next) ? inner_x_next - outer_x_next
                                                      : outer_x_next - inner_x_next;
        close_next.dy = (inner_y_next > outer_y_next) ? inner_y_next - outer_y_next
                                                      : outer_y_next - inner_y_next;
    end

    // Hold line state; clear it at each line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            past_inner_reg <= 1'b0;
            field_seen_reg <= 1'b0;
            outer_seen_reg <= 1'b0;
            outer_x_reg    <= '0;
            outer_y_reg    <= '0;
            inner_x_reg    <= '0;
            inner_y_reg    <= '0;
            line_index_reg <= '0;
        end else if (advance && pix_valid) begin
            line_index_reg <= line_index_next;
            if (pix.line_end) begin
                past_inner_reg <= 1'b0;
                field_seen_reg <= 1'b0;
                outer_seen_reg <= 1'b0;
                outer_x_reg    <= '0;
                outer_y_reg    <= '0;
                inner_x_reg    <= '0;
                inner_y_reg    <= '0;
            end else begin
                past_inner_reg <= past_inner_next;
                field_seen_reg <= field_seen_next;
                outer_seen_reg <= outer_seen_next;
                outer_x_reg    <= outer_x_next;
                outer_y_reg    <= outer_y_next;
                inner_x_reg    <= inner_x_next;
                inner_y_reg    <= inner_y_next;
            end
        end
    end

    // Close stage: clear valid under reset, load the summary while advance is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_reg.valid <= 1'b0;
        end else if (advance) begin
            close_reg <= close_next;
        end
    end

    assign close      = close_reg;
    assign line_index = line_index_reg;

endmodule

>>> design/scanline_border_ball_check_top.sv
// Top level of the scanline border ball check.
//
// Takes one classified pixel word per cycle while s_ready is high. A pixel
// passes an input register, the per-line tracker with its line close register,
// a squaring stage (two 11 x 11 multipliers) and the judge stage that counts
// near lines and loads the result register. s_ready drops only in the cycle
// where a finished set result meets a result register that still holds an
// untaken word; otherwise input flows while a result waits. The squared limit
// is registered in the cycle after a write to near_distance.
`include "assert_macros.svh"
module scanline_border_ball_check_top
    import sbbc_pkg::*;
#(
    parameter int SCAN_LINES = SCAN_LINES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_inner_hit,
    input  logic                  s_outer_hit,
    input  logic                  s_field_hit,
    input  logic [COORD_W-1:0]    s_pixel_x,
    input  logic [COORD_W-1:0]    s_pixel_y,
    input  logic                  s_line_end,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ball_valid,
    output logic [COUNT_W-1:0]    m_near_lines
);

    localparam int LINE_W = $clog2(SCAN_LINES + 1);

    logic [DIST_W-1:0]  near_distance_reg;
    logic [COUNT_W-1:0] reject_lines_reg;
    logic [LIM_W-1:0]   limit_sq_reg;

    logic               advance;
    logic               pix_valid_reg;
    pixel_t             pix_reg;
    line_close_t        close;
    logic [LINE_W-1:0]  line_index;

    logic               sq_valid_reg;
    logic               sq_cand_reg;
    logic               sq_last_reg;
    logic [SQ_W-1:0]    dx_sq_reg;
    logic [SQ_W-1:0]    dy_sq_reg;

    logic [SUM_W-1:0]   dist_sq;
    logic               line_near;
    logic [COUNT_W-1:0] near_count_reg, near_count_next;
    logic               result_load;

    logic               m_valid_reg;
    logic               m_ball_valid_reg;
    logic [COUNT_W-1:0] m_near_lines_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_distance_reg <= NEAR_DIST_RESET;
            reject_lines_reg  <= REJECT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NEAR_DISTANCE: near_distance_reg <= cfg_wdata;
                REG_REJECT_LINES:  reject_lines_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Keep the squared distance limit in a register behind near_distance_reg
    always_ff @(posedge aclk) begin
        limit_sq_reg <= LIM_W'(near_distance_reg) * LIM_W'(near_distance_reg);
    end

    // Stall only when a set result finds the result register occupied and m_ready low
    assign advance = !(sq_valid_reg && sq_last_reg && m_valid_reg && !m_ready);
    assign s_ready = advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else if (advance) begin
            pix_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            pix_reg.inner_hit <= s_inner_hit;
            pix_reg.outer_hit <= s_outer_hit;
            pix_reg.field_hit <= s_field_hit;
            pix_reg.pixel_x   <= s_pixel_x;
            pix_reg.pixel_y   <= s_pixel_y;
            pix_reg.line_end  <= s_line_end;
        end
    end

    sbbc_line_tracker #(
        .SCAN_LINES(SCAN_LINES)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .pix_valid (pix_valid_reg),
        .pix       (pix_reg),
        .close     (close),
        .line_index(line_index)
    );

    // Squaring stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (advance) begin
            sq_valid_reg <= close.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_cand_reg <= close.candidate;
            sq_last_reg <= close.set_last;
            dx_sq_reg   <= SQ_W'(close.dx) * SQ_W'(close.dx);
            dy_sq_reg   <= SQ_W'(close.dy) * SQ_W'(close.dy);
        end
    end

    // Judge the line and advance the near-line count
    assign dist_sq   = SUM_W'(dx_sq_reg) + SUM_W'(dy_sq_reg);
    assign line_near = sq_cand_reg && (dist_sq < SUM_W'(limit_sq_reg));

    always_comb begin
        near_count_next = near_count_reg;
        if (line_near && near_count_reg != COUNT_MAX) begin
            near_count_next = near_count_reg + COUNT_W'(1);
        end
    end

    assign result_load = advance && sq_valid_reg && sq_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_count_reg <= '0;
        end else if (advance && sq_valid_reg) begin
            near_count_reg <= sq_last_reg ? '0 : near_count_next;
        end
    end

    // Result register: load at set end, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_ball_valid_reg <= (near_count_next < reject_lines_reg);
            m_near_lines_reg <= near_count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ball_valid = m_ball_valid_reg;
    assign m_near_lines = m_near_lines_reg;

    // Checks
    `ASSERT_ALWAYS(a_line_index_range, aclk, aresetn,
        line_index < LINE_W'(SCAN_LINES), "line index beyond set length")
    `ASSERT_ALWAYS(a_near_lines_range, aclk, aresetn,
        !m_valid || m_near_lines <= COUNT_W'(SCAN_LINES), "near line count exceeds lines")
    `ASSERT_NEXT(a_count_restart, aclk, aresetn,
        result_load, near_count_reg == '0, "near count not cleared after set result")
    `ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        result_load, m_valid, "set result not presented")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the scanline border ball check top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbbc_pkg::*;

    localparam int RANDOM_ITEMS  = 1350;
    localparam int SETS_PER_PHASE = 4;
    localparam int HOLD_CYCLES   = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;

    // One set verdict as the block reports it
    typedef struct packed {
        logic               ball_valid;
        logic [COUNT_W-1:0] near_lines;
    } ball_verdict_t;

    // Tracks scan line state per pixel and holds the set verdicts still owed
    class ball_verdict_board;
        logic [DIST_W-1:0]  near_dist;
        logic [COUNT_W-1:0] reject_lines;
        bit                 past_inner;
        bit                 field_seen;
        bit                 outer_seen;
        logic [COORD_W-1:0] outer_x;
        logic [COORD_W-1:0] outer_y;
        logic [COORD_W-1:0] inner_x;
        logic [COORD_W-1:0] inner_y;
        int                 line_idx;
        logic [COUNT_W-1:0] near_count;
        ball_verdict_t      verdict_q[$];
        int                 mismatches;

        function new();
            near_dist = NEAR_DIST_RESET;
            reject_lines = REJECT_RESET;
            clear_line();
            line_idx = 0;
            near_count = '0;
            mismatches = 0;
        endfunction

        function void clear_line();
            past_inner = 1'b0;
            field_seen = 1'b0;
            outer_seen = 1'b0;
            outer_x = '0;
            outer_y = '0;
            inner_x = '0;
            inner_y = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NEAR_DISTANCE: near_dist = data[DIST_W-1:0];
                REG_REJECT_LINES:  reject_lines = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // Advance the line tracker by one accepted pixel word
        function void note_pixel(pixel_t p);
            int dx;
            int dy;
            int lim;
            ball_verdict_t v;
            if (!past_inner) begin
                if (p.inner_hit)
                    past_inner = 1'b1;
            end else begin
                // a field pixel wins over an outer hit until outer is found
                if (p.field_hit && !field_seen) begin
                    if (!outer_seen)
                        field_seen = 1'b1;
                end else if (p.outer_hit && !outer_seen) begin
                    outer_seen = 1'b1;
                    outer_x = p.pixel_x;
                    outer_y = p.pixel_y;
                end
                if (p.inner_hit) begin
                    inner_x = p.pixel_x;
                    inner_y = p.pixel_y;
                end
            end
            if (!p.line_end)
                return;
            // judge the finished line
            if (outer_seen && !field_seen) begin
                dx = int'(inner_x) - int'(outer_x);
                dy = int'(inner_y) - int'(outer_y);
                lim = int'(near_dist) * int'(near_dist);
                if (dx * dx + dy * dy < lim && near_count != COUNT_MAX)
                    near_count++;
            end
            clear_line();
            line_idx++;
            if (line_idx < SCAN_LINES_DEFAULT)
                return;
            v.ball_valid = (near_count < reject_lines);
            v.near_lines = near_count;
            verdict_q = {verdict_q, v};
            line_idx = 0;
            near_count = '0;
        endfunction

        // Compare one result word with the oldest verdict owed
        function void check_result(logic ball_valid, logic [COUNT_W-1:0] near_lines);
            ball_verdict_t v;
            if (verdict_q.size() == 0) begin
                flag($sformatf("unexpected result: ball_valid=%0b near_lines=%0d",
                    ball_valid, near_lines));
                return;
            end
            v = verdict_q.pop_front();
            if (ball_valid !== v.ball_valid || near_lines !== v.near_lines)
                flag($sformatf({"result mismatch: ball_valid exp %0b got %0b, ",
                    "near_lines exp %0d got %0d"},
                    v.ball_valid, ball_valid, v.near_lines, near_lines));
        endfunction

        function int pending_count();
            return verdict_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_inner_hit = 1'b0;
    logic                  s_outer_hit = 1'b0;
    logic                  s_field_hit = 1'b0;
    logic [COORD_W-1:0]    s_pixel_x = '0;
    logic [COORD_W-1:0]    s_pixel_y = '0;
    logic                  s_line_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_ball_valid;
    logic [COUNT_W-1:0]    m_near_lines;

    ball_verdict_board board = new();
    bit quiet = 1'b0;
    int ready_hold = 0;
    int cycle_count = 0;
    int pixel_count = 0;

    scanline_border_ball_check_top #(
        .SCAN_LINES(SCAN_LINES_DEFAULT)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_inner_hit(s_inner_hit),
        .s_outer_hit(s_outer_hit),
        .s_field_hit(s_field_hit),
        .s_pixel_x(s_pixel_x),
        .s_pixel_y(s_pixel_y),
        .s_line_end(s_line_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ball_valid(m_ball_valid),
        .m_near_lines(m_near_lines)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pixel_t mk(int inner, int outer, int field, int x, int y, int last);
        pixel_t p;
        p.inner_hit = 1'(inner);
        p.outer_hit = 1'(outer);
        p.field_hit = 1'(field);
        p.pixel_x = COORD_W'(x);
        p.pixel_y = COORD_W'(y);
        p.line_end = 1'(last);
        return p;
    endfunction

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            ready_hold = quiet ? 0 : pick_gap();
        end
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_ball_valid, m_near_lines);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** scanline_border_ball_check_top: FAILED **");
            $finish;
        end
    end

    // Offer one pixel word after a random gap and hold it until taken
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_inner_hit <= p.inner_hit;
        s_outer_hit <= p.outer_hit;
        s_field_hit <= p.field_hit;
        s_pixel_x <= p.pixel_x;
        s_pixel_y <= p.pixel_y;
        s_line_end <= p.line_end;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(p);
        pixel_count++;
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(data);
        board.set_reg(idx, CFG_DATA_W'(data));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every verdict has come and the pipeline is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(posedge aclk);
    endtask

    // Line that enters on an inner pixel, with pixels mostly scattered around a spot, now and then over the whole frame
    task automatic send_formed_line(int spread);
        int len;
        int bx;
        int by;
        bit wide;
        pixel_t p;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 7);
        bx = $urandom_range(0, 2047);
        by = $urandom_range(0, 2047);
        wide = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            p.inner_hit = (i == 0) ? 1'b1 : ($urandom_range(0, 99) < 35);
            p.outer_hit = ($urandom_range(0, 99) < 35);
            p.field_hit = ($urandom_range(0, 99) < 8);
            if (wide) begin
                p.pixel_x = COORD_W'($urandom_range(0, 2047));
                p.pixel_y = COORD_W'($urandom_range(0, 2047));
            end else begin
                p.pixel_x = COORD_W'(bx + int'($urandom_range(0, 2 * spread)) - spread);
                p.pixel_y = COORD_W'(by + int'($urandom_range(0, 2 * spread)) - spread);
            end
            p.line_end = (i == len - 1);
            send_pixel(p);
        end
    endtask

    // Line of random mask bits, often with no entry at all
    task automatic send_noise_line();
        int len;
        pixel_t p;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            p.inner_hit = 1'($urandom_range(0, 1));
            p.outer_hit = 1'($urandom_range(0, 1));
            p.field_hit = 1'($urandom_range(0, 1));
            p.pixel_x = COORD_W'($urandom_range(0, 2047));
            p.pixel_y = COORD_W'($urandom_range(0, 2047));
            p.line_end = (i == len - 1);
            send_pixel(p);
        end
    endtask

    initial begin
        int phase;
        int near_d;
        int reject;
        int spread;
        int start_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed set under reset settings
        // outer and field on the entry pixel are not looked at
        send_pixel(mk(1, 1, 1, 2047, 2047, 0));
        send_pixel(mk(0, 1, 0, 5, 5, 0));
        send_pixel(mk(1, 0, 0, 3, 4, 1));
        // one pixel line
        send_pixel(mk(1, 0, 0, 0, 0, 1));
        // no inner border on the line
        send_pixel(mk(0, 1, 0, 1, 1, 0));
        send_pixel(mk(0, 0, 1, 2047, 0, 1));
        // field before outer rejects the line
        send_pixel(mk(1, 0, 0, 10, 10, 0));
        send_pixel(mk(0, 0, 1, 11, 10, 0));
        send_pixel(mk(0, 1, 0, 10, 10, 0));
        send_pixel(mk(1, 0, 0, 12, 10, 1));
        // field after outer is ignored
        send_pixel(mk(1, 0, 0, 8, 8, 0));
        send_pixel(mk(0, 1, 0, 8, 8, 0));
        send_pixel(mk(0, 0, 1, 8, 9, 0));
        send_pixel(mk(1, 0, 0, 9, 8, 1));
        // outer together with field before any outer counts as field
        send_pixel(mk(1, 0, 0, 100, 100, 0));
        send_pixel(mk(0, 1, 1, 100, 100, 1));
        // no later inner pixel: distance from the origin
        send_pixel(mk(1, 0, 0, 0, 2047, 0));
        send_pixel(mk(0, 1, 0, 3, 4, 1));
        // far corners
        send_pixel(mk(1, 0, 0, 0, 0, 0));
        send_pixel(mk(0, 1, 0, 2047, 2047, 0));
        send_pixel(mk(1, 0, 0, 0, 0, 1));
        // distance equal to the limit is not near
        send_pixel(mk(1, 0, 0, 0, 0, 0));
        send_pixel(mk(0, 1, 0, 20, 0, 0));
        send_pixel(mk(1, 0, 0, 0, 0, 1));
        // just under the limit, four near lines hit the reject count
        send_pixel(mk(1, 0, 0, 5, 5, 0));
        send_pixel(mk(0, 1, 0, 19, 0, 0));
        send_pixel(mk(1, 1, 0, 0, 0, 1));

        // Random phases of whole sets, each under its own settings
        phase = 0;
        start_items = pixel_count;
        while (phase < 6 || pixel_count - start_items < RANDOM_ITEMS) begin
            wait_idle();
            case (phase)
                0: begin near_d = 0; reject = 64; end
                1: begin near_d = 1023; reject = 0; end
                2: begin near_d = 1023; reject = 64; end
                3: begin near_d = 0; reject = 0; end
                4: begin near_d = 20; reject = 4; end
                default: begin
                    near_d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(1, 48);
                    if ($urandom_range(0, 9) == 0)
                        reject = $urandom_range(0, 1) ? 64 : 0;
                    else
                        reject = $urandom_range(0, 11);
                end
            endcase
            write_cfg(REG_NEAR_DISTANCE, near_d);
            write_cfg(REG_REJECT_LINES, reject);
            repeat (2) @(posedge aclk);
            quiet = (phase % 4 == 3);
            spread = (near_d < 4) ? 3 : ((near_d > 300) ? 300 : near_d);
            for (int n = 0; n < SETS_PER_PHASE * SCAN_LINES_DEFAULT; n++) begin
                if ($urandom_range(0, 99) < 85)
                    send_formed_line(spread);
                else
                    send_noise_line();
            end
            phase++;
        end

        // Drain and report
        s_valid <= 1'b0;
        quiet = 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0)
            $display("** scanline_border_ball_check_top: PASSED **");
        else
            $display("** scanline_border_ball_check_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/sbbc_pkg.sv
design/sbbc_line_tracker.sv
design/scanline_border_ball_check_top.sv
tb/tb_top.sv
